/* sv/fatan_pkg.sv */
package fatan_pkg;

	// Default component width of the input vector.
	localparam int COMPONENT_WIDTH_DEF = 16;

	// Ratio format: unsigned Q1.15, values 0 to 32768.
	localparam int FRAC_W = 15;
	localparam int QUO_W  = FRAC_W + 1;
	localparam int ANG_W  = 16;

	// Polynomial coefficients in Q0.15, rounded to nearest.
	localparam logic [15:0] COEF_C3 = 16'd1524;
	localparam logic [15:0] COEF_C2 = 16'd5220;
	localparam logic [15:0] COEF_C1 = 16'd10736;

	// Angle constants in Q3.13.
	localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;

	localparam logic [32:0] HALF_LSB = 33'd16384;

	// Octant and special-case flags that travel with each request.
	typedef struct packed {
		logic xneg;
		logic yneg;
		logic swap;
		logic zero;
	} side_t;

	// Brings a product of two Q.15 values back to Q.15, rounding half up.
	// Every product fed in stays at or below 2^30, so bit 32 of the sum is zero.
	function automatic logic [16:0] rnd_q15(input logic [31:0] prod);
		logic [32:0] sum;
		sum = {1'b0, prod} + HALF_LSB;
		return sum[31:15];
	endfunction

endpackage

/* sv/fatan_div_cell.sv */
module fatan_div_cell #(
	parameter int CW = fatan_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_i,
	input  logic [CW-1:0]                rem_i,
	input  logic [CW-1:0]                hi_i,
	input  logic [fatan_pkg::QUO_W-1:0]  quo_i,
	input  fatan_pkg::side_t             side_i,
	output logic                         vld_o,
	output logic [CW-1:0]                rem_o,
	output logic [CW-1:0]                hi_o,
	output logic [fatan_pkg::QUO_W-1:0]  quo_o,
	output fatan_pkg::side_t             side_o
);

	logic                        vld_q;
	logic [CW-1:0]               rem_q;
	logic [CW-1:0]               hi_q;
	logic [fatan_pkg::QUO_W-1:0] quo_q;
	fatan_pkg::side_t            side_q;

	logic [CW:0]   diff;
	logic          qbit;
	logic [CW-1:0] rem_next;

	// One restoring division step: subtract the divisor if it fits.
	always_comb begin
		diff     = {1'b0, rem_i} - {1'b0, hi_i};
		qbit     = ~diff[CW];
		rem_next = qbit ? diff[CW-1:0] : rem_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// The remainder is below the divisor, so doubling it cannot overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= {rem_next[CW-2:0], 1'b0};
			hi_q   <= hi_i;
			quo_q  <= {quo_i[fatan_pkg::QUO_W-2:0], qbit};
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign hi_o   = hi_q;
	assign quo_o  = quo_q;
	assign side_o = side_q;

endmodule

/* sv/fatan_poly.sv */
module fatan_poly (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld_i,
	input  logic [fatan_pkg::QUO_W-1:0]        a_i,
	input  fatan_pkg::side_t                   side_i,
	output logic                               vld_o,
	output logic signed [fatan_pkg::ANG_W-1:0] angle_o,
	output logic                               zero_o
);

	localparam int NSTG = 6;

	logic [NSTG-1:0] vld_q;

	logic [15:0]      a_s1, a_s2, a_s3, a_s4, a_s5;
	logic [15:0]      s_s1, s_s2, s_s3;
	logic [12:0]      t_s2;
	logic [13:0]      p_s3;
	logic [13:0]      q_s4;
	logic [13:0]      w_s5;
	fatan_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [fatan_pkg::ANG_W-1:0] angle_s6;
	logic                               zero_s6;

	logic [16:0] rnd_a2, rnd_c3s, rnd_st, rnd_sp, rnd_aq;
	logic [15:0] r_s5;
	logic [16:0] r_rnd;
	logic signed [fatan_pkg::ANG_W-1:0] f0, f1, f2, f3;

	// Rounded products, one multiplier per stage except the final fold stage.
	always_comb begin
		rnd_a2  = fatan_pkg::rnd_q15(32'(a_i) * 32'(a_i));
		rnd_c3s = fatan_pkg::rnd_q15(32'(fatan_pkg::COEF_C3) * 32'(s_s1));
		rnd_st  = fatan_pkg::rnd_q15(32'(s_s2) * 32'(t_s2));
		rnd_sp  = fatan_pkg::rnd_q15(32'(s_s3) * 32'(p_s3));
		rnd_aq  = fatan_pkg::rnd_q15(32'(a_s4) * 32'(q_s4));
	end

	// First-octant angle, then the fold into the full circle.
	always_comb begin
		r_s5  = a_s5 - {2'b00, w_s5};
		r_rnd = {1'b0, r_s5} + 17'd2;
		f0    = {1'b0, r_rnd[16:2]};
		f1    = side_s5.swap ? fatan_pkg::HALF_PI_Q13 - f0 : f0;
		f2    = side_s5.xneg ? fatan_pkg::PI_Q13 - f1 : f1;
		f3    = side_s5.yneg ? -f2 : f2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: s = a*a.
			a_s1    <= a_i;
			s_s1    <= rnd_a2[15:0];
			side_s1 <= side_i;
			// Stage 2: t = C2 - C3*s.
			a_s2    <= a_s1;
			s_s2    <= s_s1;
			t_s2    <= 13'(fatan_pkg::COEF_C2 - rnd_c3s[15:0]);
			side_s2 <= side_s1;
			// Stage 3: p = C1 - s*t.
			a_s3    <= a_s2;
			s_s3    <= s_s2;
			p_s3    <= 14'(fatan_pkg::COEF_C1 - rnd_st[15:0]);
			side_s3 <= side_s2;
			// Stage 4: q = s*p.
			a_s4    <= a_s3;
			q_s4    <= rnd_sp[13:0];
			side_s4 <= side_s3;
			// Stage 5: w = a*q.
			a_s5    <= a_s4;
			w_s5    <= rnd_aq[13:0];
			side_s5 <= side_s4;
			// Stage 6: folded angle, forced to zero for the zero vector.
			angle_s6 <= side_s5.zero ? '0 : f3;
			zero_s6  <= side_s5.zero;
		end
	end

	assign vld_o   = vld_q[NSTG-1];
	assign angle_o = angle_s6;
	assign zero_o  = zero_s6;

endmodule

/* sv/fast_atan2_approximation_top.sv */
// Channel | Signals                     | Handshake
// --------+-----------------------------+---------------------
// in      | x, y                        | in_valid / in_ready
// out     | angle, zero_vector          | out_valid / out_ready
//
// One request enters per cycle unless the pipeline holds, and passes
// through a magnitude register, 16 division cells (one quotient bit
// each), and six polynomial and fold stages.
// The whole pipeline advances together; it holds while a result waits
// at the output and out_ready is low, and in_ready then falls.
// Reset clears only the valid bits.
module fast_atan2_approximation_top #(
	parameter int COMPONENT_WIDTH = fatan_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COMPONENT_WIDTH-1:0]  x,
	input  logic signed [COMPONENT_WIDTH-1:0]  y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [fatan_pkg::ANG_W-1:0] angle,
	output logic                               zero_vector
);

	localparam int CW    = COMPONENT_WIDTH;
	localparam int NCELL = fatan_pkg::QUO_W;

	logic en;

	logic [CW-1:0] ax, ay;
	logic          swap;

	logic             vld_s0;
	logic [CW-1:0]    lo_s0, hi_s0;
	fatan_pkg::side_t side_s0;

	logic                        vld_w  [NCELL+1];
	logic [CW-1:0]               rem_w  [NCELL];
	logic [CW-1:0]               hi_w   [NCELL+1];
	logic [fatan_pkg::QUO_W-1:0] quo_w  [NCELL+1];
	fatan_pkg::side_t            side_w [NCELL+1];

	// The pipeline moves unless a result is held at the output.
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	// Magnitudes; the most negative value maps to 2^(CW-1) exactly.
	always_comb begin
		ax   = x[CW-1] ? CW'(-x) : CW'(x);
		ay   = y[CW-1] ? CW'(-y) : CW'(y);
		swap = ay > ax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s0        <= swap ? ax : ay;
			hi_s0        <= swap ? ay : ax;
			side_s0.xneg <= x[CW-1];
			side_s0.yneg <= y[CW-1];
			side_s0.swap <= swap;
			side_s0.zero <= (ax == '0) && (ay == '0);
		end
	end

	assign vld_w[0]  = vld_s0;
	assign rem_w[0]  = lo_s0;
	assign hi_w[0]   = hi_s0;
	assign quo_w[0]  = '0;
	assign side_w[0] = side_s0;

	// Chain of division cells, most significant quotient bit first.
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k < NCELL - 1) begin : g_mid
			fatan_div_cell #(.CW(CW)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.vld_i  (vld_w[k]),
				.rem_i  (rem_w[k]),
				.hi_i   (hi_w[k]),
				.quo_i  (quo_w[k]),
				.side_i (side_w[k]),
				.vld_o  (vld_w[k+1]),
				.rem_o  (rem_w[k+1]),
				.hi_o   (hi_w[k+1]),
				.quo_o  (quo_w[k+1]),
				.side_o (side_w[k+1])
			);
		end else begin : g_last
			fatan_div_cell #(.CW(CW)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.vld_i  (vld_w[k]),
				.rem_i  (rem_w[k]),
				.hi_i   (hi_w[k]),
				.quo_i  (quo_w[k]),
				.side_i (side_w[k]),
				.vld_o  (vld_w[k+1]),
				.rem_o  (),
				.hi_o   (hi_w[k+1]),
				.quo_o  (quo_w[k+1]),
				.side_o (side_w[k+1])
			);
		end
	end

	// Polynomial and octant fold.
	fatan_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (vld_w[NCELL]),
		.a_i     (quo_w[NCELL]),
		.side_i  (side_w[NCELL]),
		.vld_o   (out_valid),
		.angle_o (angle),
		.zero_o  (zero_vector)
	);

endmodule
